// File: rtl/mtf_pkg.sv
// Shared types and constants of the mirrored 3x3 tile fetch unit.
package mtf_pkg;

  localparam int unsigned COUNT_BITS    = 7;
  localparam int unsigned POS_BITS      = 8;
  localparam int unsigned VALUE_BITS    = 64;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Item action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Register select, taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [POS_BITS-1:0]   row_pos;
    logic [POS_BITS-1:0]   col_pos;
    logic [VALUE_BITS-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] out_value;
    logic                  in_range;
  } out_item_t;

  // Classification of one queued operation
  typedef struct packed {
    logic is_write;
    logic in_range;
  } op_ctl_t;

endpackage

// File: rtl/mtf_front.sv
// Front end: accepts items, maps tiled positions to store addresses, drops bad loads.
module mtf_front #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned ELEM_BITS = 64,
  parameter int unsigned AW        = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mtf_pkg::in_item_t                 in_item_i,
  input  logic [mtf_pkg::COUNT_BITS-1:0]    row_count_i,
  input  logic [mtf_pkg::COUNT_BITS-1:0]    col_count_i,
  output logic                              push_o,
  input  logic                              q_full_i,
  output mtf_pkg::op_ctl_t                  op_ctl_o,
  output logic [AW-1:0]                     op_addr_o,
  output logic [ELEM_BITS-1:0]              op_data_o
);
  import mtf_pkg::*;

  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int unsigned ROW_LIM   = (MAX_ROWS > COUNT_MAX) ? COUNT_MAX : MAX_ROWS;
  localparam int unsigned COL_LIM   = (MAX_COLS > COUNT_MAX) ? COUNT_MAX : MAX_COLS;
  localparam int unsigned LIM_BITS  = 11;

  // Map one output coordinate to its source coordinate
  function automatic logic [COUNT_BITS-1:0] mirror_axis(input logic [8:0] p,
                                                        input logic [8:0] n);
    logic [8:0] n2;
    logic [8:0] s;
    n2 = n << 1;
    if (p < n) begin
      s = n - 9'd1 - p;
    end else if (p < n2) begin
      s = p - n;
    end else begin
      s = n2 + n - 9'd1 - p;
    end
    return s[COUNT_BITS-1:0];
  endfunction

  logic [COUNT_BITS-1:0] nr, nc;
  logic [8:0]            nr9, nc9, rp9, cp9;
  logic [COUNT_BITS-1:0] src_row, src_col;
  logic                  fetch_ok, load_ok, keep, accept;
  op_ctl_t               ctl_d;
  logic [AW-1:0]         addr_d;

  logic                  fr_valid_q, fr_valid_d;
  op_ctl_t               fr_ctl_q;
  logic [AW-1:0]         fr_addr_q;
  logic [ELEM_BITS-1:0]  fr_data_q;

  // Saturate the counts to the store size
  assign nr = (row_count_i > COUNT_BITS'(ROW_LIM)) ? COUNT_BITS'(ROW_LIM) : row_count_i;
  assign nc = (col_count_i > COUNT_BITS'(COL_LIM)) ? COUNT_BITS'(COL_LIM) : col_count_i;

  assign nr9 = 9'(nr);
  assign nc9 = 9'(nc);
  assign rp9 = 9'(in_item_i.row_pos);
  assign cp9 = 9'(in_item_i.col_pos);

  // Classify the item
  always_comb begin
    fetch_ok = (nr != '0) && (nc != '0) && (rp9 < ((nr9 << 1) + nr9)) &&
               (cp9 < ((nc9 << 1) + nc9));
    load_ok  = (LIM_BITS'(in_item_i.row_pos) < LIM_BITS'(MAX_ROWS)) &&
               (LIM_BITS'(in_item_i.col_pos) < LIM_BITS'(MAX_COLS));
    src_row  = mirror_axis(rp9, nr9);
    src_col  = mirror_axis(cp9, nc9);
    if (in_item_i.action == ACT_FETCH) begin
      keep           = 1'b1;
      ctl_d.is_write = 1'b0;
      ctl_d.in_range = fetch_ok;
      addr_d         = fetch_ok ? (AW'(src_row) * AW'(MAX_COLS) + AW'(src_col)) : '0;
    end else begin
      keep           = load_ok;
      ctl_d.is_write = 1'b1;
      ctl_d.in_range = 1'b0;
      addr_d         = AW'(in_item_i.row_pos) * AW'(MAX_COLS) + AW'(in_item_i.col_pos);
    end
  end

  assign push_o     = fr_valid_q && !q_full_i;
  assign in_stall_o = fr_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Advance the front register
  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = keep;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  // Hold the payload until the next accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_ctl_q  <= ctl_d;
      fr_addr_q <= addr_d;
      fr_data_q <= in_item_i.elem_value[ELEM_BITS-1:0];
    end
  end

  assign op_ctl_o  = fr_ctl_q;
  assign op_addr_o = fr_addr_q;
  assign op_data_o = fr_data_q;

endmodule

// File: rtl/mtf_queue.sv
// Two-entry queue between the front end and the back end.
module mtf_queue #(
  parameter int unsigned WIDTH = 78
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/mtf_back.sv
// Back end: element store, one write or read per cycle unless a result is stuck at the output, and the result register.
module mtf_back #(
  parameter int unsigned ELEM_BITS = 64,
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned AW        = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 pop_o,
  input  mtf_pkg::op_ctl_t     op_ctl_i,
  input  logic [AW-1:0]        op_addr_i,
  input  logic [ELEM_BITS-1:0] op_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mtf_pkg::out_item_t   out_item_o
);
  import mtf_pkg::*;

  logic [ELEM_BITS-1:0] mem_q [DEPTH];
  logic [ELEM_BITS-1:0] rd_data_q;
  logic                 range_q;
  logic                 out_valid_q, out_valid_d;
  logic                 do_write, do_read;

  // Take the next operation unless a result is stuck at the output
  assign pop_o    = !q_empty_i && !(out_valid_q && out_stall_i);
  assign do_write = pop_o && op_ctl_i.is_write;
  assign do_read  = pop_o && !op_ctl_i.is_write;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[op_addr_i] <= op_data_i;
    end
    if (do_read) begin
      rd_data_q <= mem_q[op_addr_i];
      range_q   <= op_ctl_i.in_range;
    end
  end

  // Load a new result or drop the delivered one
  always_comb begin
    out_valid_d = out_valid_q;
    if (do_read) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_item_o.in_range  = range_q;
  assign out_item_o.out_value = range_q ? VALUE_BITS'(rd_data_q) : '0;

endmodule

// File: rtl/mirror_tile_3x3_fetch_unit.sv
// Top level of the mirrored 3x3 tile fetch unit with its configuration registers.
// A fetch passes the front register, then a queue entry, then the store read before
// its result shows.
// Throughput: one item per cycle unless the queue fills behind a stalled result; the
// single port of the element store takes one load or one fetch each cycle.
// Reset clears the counts and all control state; store contents stay undefined
// until loaded, and no clearing pass runs.
module mirror_tile_3x3_fetch_unit #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned ELEM_BITS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mtf_pkg::in_item_t                     in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mtf_pkg::out_item_t                    out_item_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mtf_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [mtf_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [mtf_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);
  import mtf_pkg::*;

  localparam int unsigned MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned QW        = $bits(op_ctl_t) + AW + ELEM_BITS;

  logic [COUNT_BITS-1:0] row_count_q, col_count_q;
  logic                  cfg_wr;

  logic                  push, pop, q_full, q_empty;
  op_ctl_t               f_ctl, b_ctl;
  logic [AW-1:0]         f_addr, b_addr;
  logic [ELEM_BITS-1:0]  f_data, b_data;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROW_COUNT) begin
        row_count_q <= pwdata[COUNT_BITS-1:0];
      end else begin
        col_count_q <= pwdata[COUNT_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COL_COUNT) ? CFG_DATA_BITS'(col_count_q)
                                              : CFG_DATA_BITS'(row_count_q);

  mtf_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .ELEM_BITS (ELEM_BITS),
    .AW        (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .row_count_i (row_count_q),
    .col_count_i (col_count_q),
    .push_o      (push),
    .q_full_i    (q_full),
    .op_ctl_o    (f_ctl),
    .op_addr_o   (f_addr),
    .op_data_o   (f_data)
  );

  mtf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_ctl, f_addr, f_data}),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  ({b_ctl, b_addr, b_data}),
    .empty_o     (q_empty)
  );

  mtf_back #(
    .ELEM_BITS (ELEM_BITS),
    .DEPTH     (MEM_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .op_ctl_i    (b_ctl),
    .op_addr_i   (b_addr),
    .op_data_i   (b_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/mtf_checker.sv
// Port-level checks of the mirrored 3x3 tile fetch unit, bound to the top level.
module mtf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mtf_pkg::out_item_t out_item_o,
  input logic               pready
);
  import mtf_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // Out-of-range results carry a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.in_range |-> out_item_o.out_value == '0)
    else $error("out-of-range result with nonzero value");

  // Reset clears any result: none shows just after reset is seen low
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Configuration port never waits
  assert property (@(posedge clk_i) pready)
    else $error("configuration port not ready");

endmodule

bind mirror_tile_3x3_fetch_unit mtf_checker u_mtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

// File: tb/sv/mirror_tile_3x3_fetch_unit_tb.sv
// Self-checking testbench of the mirrored 3x3 tile fetch unit.
`timescale 1ns / 100ps

module mirror_tile_3x3_fetch_unit_tb;
  import mtf_pkg::*;

  localparam int unsigned ROWS_MAX        = 64;
  localparam int unsigned COLS_MAX        = 64;
  localparam int unsigned TILES           = 3;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  localparam int unsigned PRESSURE_ITEMS  = 48;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  in_item_t                 in_item_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_item_t                out_item_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr       = '0;
  logic [CFG_DATA_BITS-1:0] pwdata      = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Shadow of the block's registers and element store
  logic [COUNT_BITS-1:0]    row_cfg = '0;
  logic [COUNT_BITS-1:0]    col_cfg = '0;
  logic [VALUE_BITS-1:0]    matrix_copy [ROWS_MAX*COLS_MAX];
  bit                       entry_loaded [ROWS_MAX*COLS_MAX];
  int unsigned              loaded_addrs [$];
  out_item_t                fetch_results_due [$];

  int unsigned              error_count  = 0;
  bit                       quiet_phase  = 1'b0;
  bit                       rx_hold_req  = 1'b0;
  int unsigned              stall_left   = 0;

  mirror_tile_3x3_fetch_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gap length for both sides: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (quiet_phase || roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int unsigned eff_count(input int unsigned v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Map an output coordinate back onto the stored matrix along one axis
  function automatic int unsigned fold_axis(input int unsigned p, input int unsigned n);
    if (p < n) return n - 1 - p;
    if (p < 2 * n) return p - n;
    return 3 * n - 1 - p;
  endfunction

  // Pick an output coordinate in a random tile that maps onto source index s
  function automatic int unsigned unfold_axis(input int unsigned s, input int unsigned n);
    case ($urandom_range(2))
      0:       return n - 1 - s;
      1:       return n + s;
      default: return 3 * n - 1 - s;
    endcase
  endfunction

  function automatic bit fetch_in_range(input int unsigned r, input int unsigned c);
    int unsigned nr, nc;
    nr = eff_count(row_cfg, ROWS_MAX);
    nc = eff_count(col_cfg, COLS_MAX);
    return nr != 0 && nc != 0 && r < TILES * nr && c < TILES * nc;
  endfunction

  function automatic int unsigned source_addr(input int unsigned r, input int unsigned c);
    return fold_axis(r, eff_count(row_cfg, ROWS_MAX)) * COLS_MAX
         + fold_axis(c, eff_count(col_cfg, COLS_MAX));
  endfunction

  function automatic out_item_t predict_fetch(input int unsigned r, input int unsigned c);
    out_item_t res;
    res = '0;
    if (fetch_in_range(r, c)) begin
      res.out_value = matrix_copy[source_addr(r, c)];
      res.in_range  = 1'b1;
    end
    return res;
  endfunction

  function automatic in_item_t load_item(input int unsigned r, input int unsigned c,
                                         input logic [VALUE_BITS-1:0] v);
    in_item_t item;
    item.action     = ACT_LOAD;
    item.row_pos    = POS_BITS'(r);
    item.col_pos    = POS_BITS'(c);
    item.elem_value = v;
    return item;
  endfunction

  function automatic in_item_t fetch_item(input int unsigned r, input int unsigned c);
    in_item_t item;
    item.action     = ACT_FETCH;
    item.row_pos    = POS_BITS'(r);
    item.col_pos    = POS_BITS'(c);
    item.elem_value = {$urandom, $urandom};
    return item;
  endfunction

  // Mostly fetches of loaded entries and loads inside the counts, the rest noise
  function automatic in_item_t next_random_item();
    int unsigned roll, nr, nc, tries, addr;
    in_item_t    item;
    roll = $urandom_range(99);
    nr   = eff_count(row_cfg, ROWS_MAX);
    nc   = eff_count(col_cfg, COLS_MAX);
    if (roll < 45 && nr != 0 && nc != 0 && loaded_addrs.size() != 0) begin
      for (tries = 0; tries < 8; tries++) begin
        addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
        if (addr / COLS_MAX < nr && addr % COLS_MAX < nc)
          return fetch_item(unfold_axis(addr / COLS_MAX, nr), unfold_axis(addr % COLS_MAX, nc));
      end
    end
    if (roll < 85 && nr != 0 && nc != 0)
      return load_item($urandom_range(nr - 1), $urandom_range(nc - 1), {$urandom, $urandom});
    item = fetch_item($urandom_range(255), $urandom_range(255));
    // Never read an entry that was not loaded; turn such a fetch, and half of the others, into a load
    if ($urandom_range(1) == 0 ||
        (fetch_in_range(item.row_pos, item.col_pos) &&
         !entry_loaded[source_addr(item.row_pos, item.col_pos)]))
      item.action = ACT_LOAD;
    return item;
  endfunction

  // Offer one item, hold it until accepted, then update the shadow
  task automatic send_item(input in_item_t item);
    int unsigned gap, addr;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (item.action == ACT_LOAD) begin
      if (item.row_pos < ROWS_MAX && item.col_pos < COLS_MAX) begin
        addr = item.row_pos * COLS_MAX + item.col_pos;
        matrix_copy[addr] = item.elem_value;
        if (!entry_loaded[addr]) begin
          entry_loaded[addr] = 1'b1;
          loaded_addrs.push_back(addr);
        end
      end
    end else begin
      fetch_results_due.push_back(predict_fetch(item.row_pos, item.col_pos));
    end
    @(negedge clk_i);
  endtask

  // Drop valid, wait for all fetch results, then let loads drain
  task automatic settle();
    in_valid_i = 1'b0;
    while (fetch_results_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one count register and read it back
  task automatic write_count(input logic reg_sel, input logic [CFG_DATA_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] readback;
    paddr   = {reg_sel, 2'b00};
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (reg_sel == REG_ROW_COUNT) row_cfg = value[COUNT_BITS-1:0];
    else col_cfg = value[COUNT_BITS-1:0];
    if (readback !== CFG_DATA_BITS'(value[COUNT_BITS-1:0])) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, reg_sel,
               CFG_DATA_BITS'(value[COUNT_BITS-1:0]), readback);
      error_count++;
    end
  endtask

  // Small 2x3 matrix: tile corners, edges, out of range, ignored loads
  task automatic test_tile_edges();
    write_count(REG_ROW_COUNT, 2);
    write_count(REG_COL_COUNT, 3);
    send_item(load_item(0, 0, '0));
    send_item(load_item(0, 1, '1));
    send_item(load_item(0, 2, 64'h8000_0000_0000_0001));
    send_item(load_item(1, 0, 64'h0123_4567_89AB_CDEF));
    send_item(load_item(1, 1, 64'hFEDC_BA98_7654_3210));
    send_item(load_item(1, 2, 64'h5555_AAAA_5555_AAAA));
    // drop loads outside the store, keep one beyond the counts
    send_item(load_item(64, 0, '1));
    send_item(load_item(0, 64, '1));
    send_item(load_item(255, 255, '1));
    send_item(load_item(63, 63, {$urandom, $urandom}));
    send_item(fetch_item(0, 0));
    send_item(fetch_item(5, 8));
    send_item(fetch_item(2, 3));
    send_item(fetch_item(3, 5));
    send_item(fetch_item(1, 4));
    send_item(fetch_item(0, 8));
    send_item(fetch_item(5, 0));
    send_item(fetch_item(6, 0));
    send_item(fetch_item(0, 9));
    send_item(fetch_item(255, 255));
  endtask

  // A zero count makes every fetch out of range
  task automatic test_zero_counts();
    settle();
    write_count(REG_ROW_COUNT, 0);
    send_item(fetch_item(0, 0));
    settle();
    write_count(REG_ROW_COUNT, 2);
    write_count(REG_COL_COUNT, 0);
    send_item(fetch_item(1, 1));
  endtask

  // Counts above the store size clamp to it
  task automatic test_count_saturation();
    settle();
    write_count(REG_ROW_COUNT, 127);
    write_count(REG_COL_COUNT, 65);
    send_item(load_item(0, 63, {$urandom, $urandom}));
    send_item(fetch_item(0, 0));
    send_item(fetch_item(191, 191));
    send_item(fetch_item(64, 127));
    send_item(fetch_item(192, 0));
    send_item(fetch_item(0, 192));
  endtask

  // Random traffic over a sweep of count settings
  task automatic test_random_traffic();
    int unsigned phase, counted, rows, cols;
    in_item_t    item;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin rows = 1;   cols = 1;   end
        1:       begin rows = 64;  cols = 64;  end
        2:       begin rows = 127; cols = 127; end
        3:       begin rows = 0;   cols = 9;   end
        4:       begin rows = 3;   cols = 0;   end
        5:       begin rows = 64;  cols = 2;   end
        6:       begin rows = 2;   cols = 64;  end
        default: begin rows = $urandom_range(127); cols = $urandom_range(127); end
      endcase
      settle();
      write_count(REG_ROW_COUNT, rows);
      write_count(REG_COL_COUNT, cols);
      quiet_phase = (phase % 3 == 1);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        item = next_random_item();
        send_item(item);
        if (item.action == ACT_FETCH || (item.row_pos < ROWS_MAX && item.col_pos < COLS_MAX))
          counted++;
      end
      quiet_phase = 1'b0;
    end
  endtask

  // Hold the result side off for a long stretch while items keep coming
  task automatic test_backpressure();
    int unsigned k;
    settle();
    write_count(REG_ROW_COUNT, 64);
    write_count(REG_COL_COUNT, 64);
    quiet_phase = 1'b1;
    rx_hold_req = 1'b1;
    @(negedge clk_i);
    for (k = 0; k < PRESSURE_ITEMS; k++) send_item(next_random_item());
    quiet_phase = 1'b0;
  endtask

  // Drive the result stall: random stretches, or a long hold on request
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      stall_left  = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      stall_left  = pick_gap();
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fetch_results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none actual value %h in_range %b",
                 $time, out_item_o.out_value, out_item_o.in_range);
        error_count++;
      end else begin
        want = fetch_results_due.pop_front();
        if (out_item_o.out_value !== want.out_value) begin
          $display("%0t: out_value expected %h actual %h", $time, want.out_value,
                   out_item_o.out_value);
          error_count++;
        end
        if (out_item_o.in_range !== want.in_range) begin
          $display("%0t: in_range expected %b actual %b", $time, want.in_range,
                   out_item_o.in_range);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[mirror_tile_3x3_fetch_unit] ERROR");
    $finish;
  end

  initial begin : run
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_tile_edges();
    test_zero_counts();
    test_count_saturation();
    test_random_traffic();
    test_backpressure();
    settle();
    if (error_count == 0) begin
      $display("[mirror_tile_3x3_fetch_unit] OK");
    end else begin
      $display("[mirror_tile_3x3_fetch_unit] ERROR");
    end
    $finish;
  end

endmodule
